// ===== design/wlcf_pkg.sv =====
// Shared types, stage map and constants for the worm-like-chain edge force pipeline.
// Used by wlcf_flow and wlc_edge_force_damage; depends on nothing.
`default_nettype none
package wlcf_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_WRAP_SHIFT_X   = 3'd0,
    CFG_WRAP_SHIFT_Y   = 3'd1,
    CFG_FORCE_SCALE    = 3'd2,
    CFG_RATE_PREFACTOR = 3'd3,
    CFG_RATE_EXP_SCALE = 3'd4,
    CFG_DAMAGE_ON      = 3'd5
  } cfg_idx_t;

  // Stage map of the pipeline.
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 17;
  localparam int REC_STEPS  = 28;
  localparam int SER_TERMS  = 8;

  localparam int ST_MAG   = 0;
  localparam int ST_SQR   = 1;
  localparam int ST_SUM   = 2;
  localparam int ST_SQRT0 = 3;
  localparam int ST_CMP   = ST_SQRT0 + SQRT_STEPS;
  localparam int ST_DIV0  = ST_CMP + 1;
  localparam int ST_UU    = ST_DIV0 + DIV_STEPS;
  localparam int ST_REC0  = ST_UU + 1;
  localparam int ST_FORCE = ST_REC0 + REC_STEPS;
  localparam int ST_MUL   = ST_FORCE + 1;
  localparam int ST_SIGN  = ST_MUL + 1;
  localparam int ST_LOG   = ST_SIGN + 1;
  localparam int ST_FRAC  = ST_LOG + 1;
  localparam int ST_SER0  = ST_FRAC + 1;
  localparam int ST_INC   = ST_SER0 + 2 * SER_TERMS;
  localparam int ST_OUT   = ST_INC + 1;
  localparam int NS       = ST_OUT + 1;

  localparam logic [31:0] FORCE_SCALE_RESET = 32'h0001_0000;
  localparam logic [31:0] DAMAGE_ONE        = 32'h0001_0000;
  localparam logic [29:0] QUARTER_Q16       = 30'd16384;
  localparam logic [20:0] EXP_CAP           = 21'd1507328;
  localparam logic [30:0] LOG2E_Q30         = 31'd1549082005;
  localparam logic [29:0] LN2_Q30           = 30'd744261118;
  localparam logic [30:0] ONE_Q30           = 31'h4000_0000;

  // Everything an edge carries down the pipeline.
  typedef struct packed {
    logic        over;
    logic        neg_x;
    logic        neg_y;
    logic [31:0] len;
    logic [31:0] dmg;
    logic [31:0] mx;
    logic [31:0] my;
    logic [63:0] sqx;
    logic [63:0] sqy;
    logic [63:0] v;
    logic [63:0] res;
    logic [31:0] s;
    logic [15:0] t;
    logic [32:0] trem;
    logic [16:0] rx;
    logic [32:0] rxrem;
    logic [16:0] ry;
    logic [32:0] ryrem;
    logic [32:0] uu;
    logic [27:0] q;
    logic [32:0] qrem;
    logic [44:0] frc;
    logic [45:0] cx;
    logic [45:0] cy;
    logic [54:0] plo;
    logic [53:0] phi;
    logic [47:0] fx;
    logic [47:0] fy;
    logic [20:0] x;
    logic [5:0]  n;
    logic [15:0] f;
    logic [29:0] z;
    logic [30:0] term;
    logic [29:0] tp;
    logic [31:0] sum;
    logic [33:0] inc;
  } pipe_t;

  // Reciprocal ceil(2^33 / d) for exact division of a 30-bit value by d in 1..8.
  function automatic logic [33:0] recip8(input int d);
    logic [33:0] m;
    case (d)
      1:       m = 34'd8589934592;
      2:       m = 34'd4294967296;
      3:       m = 34'd2863311531;
      4:       m = 34'd2147483648;
      5:       m = 34'd1717986919;
      6:       m = 34'd1431655766;
      7:       m = 34'd1227133514;
      8:       m = 34'd1073741824;
      default: m = 34'd0;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== design/wlcf_flow.sv =====
// Valid bits and per-stage load enables for the edge force pipeline.
// Depends on wlcf_pkg for the stage count.
`default_nettype none
module wlcf_flow (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    out_ready,
  output logic                    in_ready,
  output logic [wlcf_pkg::NS-1:0] load,
  output logic [wlcf_pkg::NS-1:0] valid
);
  import wlcf_pkg::*;

  // A stage may load when it is empty or its item moves on, so bubbles close up.
  logic [NS:0] chain;

  assign chain[NS] = out_ready;

  for (genvar k = 0; k < NS; k++) begin : g_flow
    assign chain[k] = !valid[k] || chain[k+1];
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          valid[k] <= 1'b0;
        end else if (chain[k]) begin
          valid[k] <= in_valid;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (rst) begin
          valid[k] <= 1'b0;
        end else if (chain[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  assign load     = chain[NS-1:0];
  assign in_ready = chain[0];

endmodule
`default_nettype wire

// ===== design/wlc_edge_force_damage.sv =====
// Top level of the worm-like-chain edge force and damage kernel.
// Depends on wlcf_pkg and wlcf_flow.
`default_nettype none
// Usage: one live edge enters per accepted item on the input channel
// (in_valid/in_ready) with both endpoints, contour length, wrap flag and
// damage. One result item leaves on the output channel (out_valid/out_ready)
// with the force vector, the new damage and the break flag, in input order.
// A 105-stage pipeline: with no stall one item is taken every cycle.
// The longest parts are the square root (one result bit per stage, 32
// stages), the divider for s/L and the unit vector (17 stages) and the
// reciprocal of (1-t)^2 (28 stages); the exp series takes two stages a term.
// When the receiver stalls, the last stage holds its item and the stages
// behind it keep filling until no bubble is left; in_ready then drops.
// Reset empties the pipeline and returns the registers to their defaults
// (force_scale 1.0, all others zero). Configuration writes on cfg_valid,
// cfg_index and cfg_data are always taken and are meant to happen only
// while no item is in flight; unknown indexes are ignored.
module wlc_edge_force_damage (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] end_a_x,
  input  logic [31:0] end_a_y,
  input  logic [31:0] end_b_x,
  input  logic [31:0] end_b_y,
  input  logic [31:0] contour_length,
  input  logic        wrapped,
  input  logic [31:0] damage_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] force_x,
  output logic [47:0] force_y,
  output logic [31:0] damage_out,
  output logic        broken,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import wlcf_pkg::*;

  logic [31:0] wrap_shift_x;
  logic [31:0] wrap_shift_y;
  logic [31:0] force_scale;
  logic [31:0] rate_prefactor;
  logic [31:0] rate_exponent_scale;
  logic        damage_update_on;

  logic [NS-1:0] load;
  logic [NS-1:0] valid;
  pipe_t         st [NS];

  // Configuration registers; the port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_shift_x        <= '0;
      wrap_shift_y        <= '0;
      force_scale         <= FORCE_SCALE_RESET;
      rate_prefactor      <= '0;
      rate_exponent_scale <= '0;
      damage_update_on    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WRAP_SHIFT_X:   wrap_shift_x        <= cfg_data;
        CFG_WRAP_SHIFT_Y:   wrap_shift_y        <= cfg_data;
        CFG_FORCE_SCALE:    force_scale         <= cfg_data;
        CFG_RATE_PREFACTOR: rate_prefactor      <= cfg_data;
        CFG_RATE_EXP_SCALE: rate_exponent_scale <= cfg_data;
        CFG_DAMAGE_ON:      damage_update_on    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  wlcf_flow u_flow (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .load      (load),
    .valid     (valid)
  );

  for (genvar k = 0; k < NS; k++) begin : g_stage
    pipe_t nxt;

    if (k == ST_MAG) begin : g_mag
      // Separation d = a - (b + shift) and its magnitude; a component of
      // 2^32 or more makes the edge overstretched right away.
      always_comb begin
        logic [33:0] shx, shy, dxs, dys, ax, ay;
        shx = wrapped ? {{2{wrap_shift_x[31]}}, wrap_shift_x} : '0;
        shy = wrapped ? {{2{wrap_shift_y[31]}}, wrap_shift_y} : '0;
        dxs = {{2{end_a_x[31]}}, end_a_x} - {{2{end_b_x[31]}}, end_b_x} - shx;
        dys = {{2{end_a_y[31]}}, end_a_y} - {{2{end_b_y[31]}}, end_b_y} - shy;
        ax  = dxs[33] ? (34'd0 - dxs) : dxs;
        ay  = dys[33] ? (34'd0 - dys) : dys;
        nxt       = '0;
        nxt.neg_x = dxs[33];
        nxt.neg_y = dys[33];
        nxt.mx    = ax[31:0];
        nxt.my    = ay[31:0];
        nxt.over  = (|ax[33:32]) | (|ay[33:32]);
        nxt.len   = contour_length;
        nxt.dmg   = damage_in;
      end
    end else if (k == ST_SQR) begin : g_sqr
      always_comb begin
        nxt     = st[k-1];
        nxt.sqx = 64'(st[k-1].mx) * 64'(st[k-1].mx);
        nxt.sqy = 64'(st[k-1].my) * 64'(st[k-1].my);
      end
    end else if (k == ST_SUM) begin : g_sum
      // A squared length past 64 bits also counts as overstretched.
      always_comb begin
        logic [64:0] sq;
        sq       = {1'b0, st[k-1].sqx} + {1'b0, st[k-1].sqy};
        nxt      = st[k-1];
        nxt.over = st[k-1].over | sq[64];
        nxt.v    = sq[63:0];
        nxt.res  = '0;
      end
    end else if (k >= ST_SQRT0 && k < ST_CMP) begin : g_sqrt
      // One digit pair of the integer square root per stage.
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * (k - ST_SQRT0));
      always_comb begin
        logic [64:0] trial;
        trial = {1'b0, st[k-1].res} + {1'b0, BIT};
        nxt   = st[k-1];
        if ({1'b0, st[k-1].v} >= trial) begin
          nxt.v   = st[k-1].v - trial[63:0];
          nxt.res = (st[k-1].res >> 1) + BIT;
        end else begin
          nxt.res = st[k-1].res >> 1;
        end
      end
    end else if (k == ST_CMP) begin : g_cmp
      // Break test 100*s >= 99*L; the dividers are seeded with s, |dx| and |dy|.
      always_comb begin
        logic [38:0] s100, l99;
        s100      = 39'(st[k-1].res[31:0]) * 39'd100;
        l99       = 39'(st[k-1].len) * 39'd99;
        nxt       = st[k-1];
        nxt.over  = st[k-1].over | (s100 >= l99);
        nxt.s     = st[k-1].res[31:0];
        nxt.t     = '0;
        nxt.trem  = {1'b0, st[k-1].res[31:0]};
        nxt.rx    = '0;
        nxt.rxrem = {2'b0, st[k-1].mx[31:1]};
        nxt.ry    = '0;
        nxt.ryrem = {2'b0, st[k-1].my[31:1]};
      end
    end else if (k >= ST_DIV0 && k < ST_UU) begin : g_div
      // t = s*2^16/L takes 16 steps; the unit vector |d|*2^16/s takes 17.
      localparam int J = k - ST_DIV0;
      always_comb begin
        logic [33:0] rt, rxs, rys;
        nxt = st[k-1];
        rt  = {st[k-1].trem, 1'b0};
        rxs = {st[k-1].rxrem, (J == 0) ? st[k-1].mx[0] : 1'b0};
        rys = {st[k-1].ryrem, (J == 0) ? st[k-1].my[0] : 1'b0};
        if (J < 16) begin
          if (rt >= {2'b0, st[k-1].len}) begin
            nxt.trem = 33'(rt - {2'b0, st[k-1].len});
            nxt.t    = {st[k-1].t[14:0], 1'b1};
          end else begin
            nxt.trem = rt[32:0];
            nxt.t    = {st[k-1].t[14:0], 1'b0};
          end
        end
        if (rxs >= {2'b0, st[k-1].s}) begin
          nxt.rxrem = 33'(rxs - {2'b0, st[k-1].s});
          nxt.rx    = {st[k-1].rx[15:0], 1'b1};
        end else begin
          nxt.rxrem = rxs[32:0];
          nxt.rx    = {st[k-1].rx[15:0], 1'b0};
        end
        if (rys >= {2'b0, st[k-1].s}) begin
          nxt.ryrem = 33'(rys - {2'b0, st[k-1].s});
          nxt.ry    = {st[k-1].ry[15:0], 1'b1};
        end else begin
          nxt.ryrem = rys[32:0];
          nxt.ry    = {st[k-1].ry[15:0], 1'b0};
        end
      end
    end else if (k == ST_UU) begin : g_uu
      // (1-t)^2 in Q32; the reciprocal quotient 2^46/u^2 fits 28 bits because
      // an intact edge has t below 0.99, so the divider starts at 2^46 >> 28.
      always_comb begin
        logic [16:0] u;
        logic [33:0] p;
        u        = 17'h10000 - {1'b0, st[k-1].t};
        p        = {17'b0, u} * {17'b0, u};
        nxt      = st[k-1];
        nxt.uu   = p[32:0];
        nxt.q    = '0;
        nxt.qrem = 33'h40000;
      end
    end else if (k >= ST_REC0 && k < ST_FORCE) begin : g_rec
      always_comb begin
        logic [33:0] r;
        r   = {st[k-1].qrem, 1'b0};
        nxt = st[k-1];
        if (r >= {1'b0, st[k-1].uu}) begin
          nxt.qrem = 33'(r - {1'b0, st[k-1].uu});
          nxt.q    = {st[k-1].q[26:0], 1'b1};
        end else begin
          nxt.qrem = r[32:0];
          nxt.q    = {st[k-1].q[26:0], 1'b0};
        end
      end
    end else if (k == ST_FORCE) begin : g_force
      // F = force_scale * (t + 1/(4(1-t)^2) - 1/4); zero once overstretched.
      always_comb begin
        logic [29:0] tm;
        logic [60:0] p;
        tm      = 30'(st[k-1].t) + 30'(st[k-1].q) - QUARTER_Q16;
        p       = 61'(tm[28:0]) * 61'(force_scale);
        nxt     = st[k-1];
        nxt.frc = st[k-1].over ? '0 : p[60:16];
      end
    end else if (k == ST_MUL) begin : g_mul
      // Force components, and the exponent product split in two halves.
      always_comb begin
        logic [61:0] px, py;
        px      = 62'(st[k-1].frc) * 62'(st[k-1].rx);
        py      = 62'(st[k-1].frc) * 62'(st[k-1].ry);
        nxt     = st[k-1];
        nxt.cx  = px[61:16];
        nxt.cy  = py[61:16];
        nxt.plo = 55'(rate_exponent_scale) * 55'(st[k-1].frc[22:0]);
        nxt.phi = 54'(rate_exponent_scale) * 54'(st[k-1].frc[44:23]);
      end
    end else if (k == ST_SIGN) begin : g_sign
      // The components never exceed F, so they need no clamp; x is capped at EXP_CAP.
      always_comb begin
        logic [76:0] pr;
        logic [60:0] xr;
        pr     = 77'(st[k-1].plo) + {st[k-1].phi, 23'b0};
        xr     = pr[76:16];
        nxt    = st[k-1];
        nxt.fx = st[k-1].neg_x ? (48'd0 - {2'b0, st[k-1].cx}) : {2'b0, st[k-1].cx};
        nxt.fy = st[k-1].neg_y ? (48'd0 - {2'b0, st[k-1].cy}) : {2'b0, st[k-1].cy};
        nxt.x  = (xr >= 61'(EXP_CAP)) ? EXP_CAP : xr[20:0];
      end
    end else if (k == ST_LOG) begin : g_log
      // exp(x) = 2^n * 2^f with y = x*log2(e).
      always_comb begin
        logic [51:0] y;
        y     = 52'(st[k-1].x) * 52'(LOG2E_Q30);
        nxt   = st[k-1];
        nxt.n = y[51:46];
        nxt.f = y[45:30];
      end
    end else if (k == ST_FRAC) begin : g_frac
      always_comb begin
        logic [45:0] zp;
        zp       = 46'(st[k-1].f) * 46'(LN2_Q30);
        nxt      = st[k-1];
        nxt.z    = zp[45:16];
        nxt.term = ONE_Q30;
        nxt.sum  = 32'(ONE_Q30);
      end
    end else if (k >= ST_SER0 && k < ST_INC && ((k - ST_SER0) % 2 == 0)) begin : g_ser_mul
      // Taylor term times z.
      always_comb begin
        logic [60:0] p;
        p      = 61'(st[k-1].term) * 61'(st[k-1].z);
        nxt    = st[k-1];
        nxt.tp = p[59:30];
      end
    end else if (k >= ST_SER0 && k < ST_INC) begin : g_ser_div
      // Divide by the term number through its reciprocal and accumulate.
      localparam int I = (k - ST_SER0) / 2 + 1;
      always_comb begin
        logic [63:0] p;
        logic [30:0] tn;
        p        = 64'(st[k-1].tp) * 64'(recip8(I));
        tn       = p[63:33];
        nxt      = st[k-1];
        nxt.term = tn;
        nxt.sum  = st[k-1].sum + 32'(tn);
      end
    end else if (k == ST_INC) begin : g_inc
      always_comb begin
        logic [63:0] p;
        p       = 64'(rate_prefactor) * 64'(st[k-1].sum);
        nxt     = st[k-1];
        nxt.inc = p[63:30];
      end
    end else begin : g_out
      // Scale by 2^n with saturation; with damage updates on, add to the damage and test breaking.
      // An overstretched edge restarts from zero damage. The over flag
      // leaves this stage as the break flag.
      always_comb begin
        logic [31:0] dmg0, incs;
        logic [33:0] lim, sh;
        logic [32:0] total;
        logic [31:0] dnew;
        dmg0  = st[k-1].over ? '0 : st[k-1].dmg;
        lim   = 34'(32'hFFFF_FFFF >> st[k-1].n);
        sh    = st[k-1].inc << st[k-1].n;
        if (st[k-1].inc == '0) begin
          incs = '0;
        end else if (st[k-1].n >= 6'd32 || st[k-1].inc > lim) begin
          incs = '1;
        end else begin
          incs = sh[31:0];
        end
        total = {1'b0, dmg0} + {1'b0, incs};
        dnew  = total[32] ? '1 : total[31:0];
        nxt   = st[k-1];
        if (damage_update_on) begin
          nxt.dmg  = dnew;
          nxt.over = st[k-1].over | (dnew > DAMAGE_ONE);
        end else begin
          nxt.dmg  = dmg0;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (load[k]) begin
        st[k] <= nxt;
      end
    end
  end

  assign out_valid  = valid[NS-1];
  assign force_x    = st[NS-1].fx;
  assign force_y    = st[NS-1].fy;
  assign damage_out = st[NS-1].dmg;
  assign broken     = st[NS-1].over;

endmodule
`default_nettype wire
